// ----- sv/gnss_fix_quality_qualifier_assert.svh -----
// Assertion macros shared by the fix quality qualifier RTL.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef GNSS_FIX_QUALITY_QUALIFIER_ASSERT_SVH
`define GNSS_FIX_QUALITY_QUALIFIER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GFQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gfq: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GFQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gfq: next-cycle check failed");

`endif

// ----- sv/gfq_pkg.sv -----
// Package for the fix quality qualifier: widths, register field layout,
// configuration and match types, and shared helper functions. No dependencies.
package gfq_pkg;

  localparam int NumEntries = 4;
  localparam int NumLevels = 4;
  localparam int ScanLevels = (NumLevels < NumEntries) ? NumLevels : NumEntries;
  localparam int EntryIdxW = $clog2(NumEntries);

  localparam int TimeW = 64;
  localparam int StatusW = 8;
  localparam int LatW = 31;
  localparam int LonW = 32;
  localparam int LevelW = 3;
  localparam int DimW = 3;
  localparam int PrecW = 16;
  localparam int EntryW = 42;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 42;

  localparam int EntryStatusW = 9;
  localparam int DwellMsW = 16;
  localparam int DwellUsW = 26;
  localparam int UsPerMs = 1000;

  localparam int EnBit = 0;
  localparam int StatusLsb = 1;
  localparam int DwellLsb = 10;
  localparam int PrecLsb = 26;

  localparam int NearZeroE7 = 1000;
  localparam logic signed [LatW-1:0] LatNearHi = LatW'(NearZeroE7);
  localparam logic signed [LatW-1:0] LatNearLo = -LatNearHi;
  localparam logic signed [LonW-1:0] LonNearHi = LonW'(NearZeroE7);
  localparam logic signed [LonW-1:0] LonNearLo = -LonNearHi;

  localparam logic [TimeW-1:0] LossTimeoutUs = TimeW'(1000000);
  localparam logic [DimW-1:0] DimReset = DimW'(2);
  localparam logic [EntryStatusW-1:0] StatusAny = '1;

  typedef logic signed [LevelW-1:0] level_t;
  localparam level_t LevelNone = level_t'(-1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENTRY0,
    CFG_ENTRY1,
    CFG_ENTRY2,
    CFG_ENTRY3,
    CFG_BYPASS,
    CFG_INS_DIM
  } cfg_reg_t;

  typedef struct packed {
    logic [NumEntries-1:0][EntryW-1:0] entries;
    logic                              bypass;
    logic [DimW-1:0]                   dim;
  } cfg_t;

  typedef struct packed {
    level_t              level;
    logic [DwellUsW-1:0] dwell_us;
  } match_t;

  function automatic logic entry_en(input logic [EntryW-1:0] e);
    return e[EnBit];
  endfunction

  function automatic logic [EntryStatusW-1:0] entry_status(input logic [EntryW-1:0] e);
    return e[StatusLsb +: EntryStatusW];
  endfunction

  function automatic logic [DwellUsW-1:0] entry_dwell_us(input logic [EntryW-1:0] e);
    return DwellUsW'(e[DwellLsb +: DwellMsW]) * DwellUsW'(UsPerMs);
  endfunction

  function automatic logic [PrecW-1:0] entry_prec(input logic [EntryW-1:0] e);
    return e[PrecLsb +: PrecW];
  endfunction

  // True when later is not below earlier and the gap reaches span.
  function automatic logic elapsed_at_least(input logic [TimeW-1:0] later,
                                            input logic [TimeW-1:0] earlier,
                                            input logic [TimeW-1:0] span);
    logic [TimeW:0] diff;
    diff = {1'b0, later} - {1'b0, earlier};
    return !diff[TimeW] && (diff[TimeW-1:0] >= span);
  endfunction

endpackage

// ----- sv/gfq_in_if.sv -----
// Input channel of the fix quality qualifier: valid/ready plus one fix report.
// Depends on gfq_pkg.
interface gfq_in_if;
  import gfq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [TimeW-1:0]       frame_time_us;
  logic [TimeW-1:0]       fix_time_us;
  logic [StatusW-1:0]     fix_status;
  logic signed [LatW-1:0] latitude_e7;
  logic signed [LonW-1:0] longitude_e7;

  modport source (output valid, frame_time_us, fix_time_us, fix_status,
                  latitude_e7, longitude_e7, input ready);
  modport sink (input valid, frame_time_us, fix_time_us, fix_status,
                latitude_e7, longitude_e7, output ready);
endinterface

// ----- sv/gfq_out_if.sv -----
// Result channel of the fix quality qualifier: valid/ready plus one result.
// Depends on gfq_pkg.
interface gfq_out_if;
  import gfq_pkg::*;

  logic             valid;
  logic             ready;
  logic             fix_valid;
  logic             attributes_set;
  level_t           level;
  logic [DimW-1:0]  dimension_out;
  logic [PrecW-1:0] precision_out;

  modport source (output valid, fix_valid, attributes_set, level, dimension_out,
                  precision_out, input ready);
  modport sink (input valid, fix_valid, attributes_set, level, dimension_out,
                precision_out, output ready);
endinterface

// ----- sv/gfq_cfg_regs.sv -----
// Configuration register bank: level table entries, bypass and dimension.
// Depends on gfq_pkg.
module gfq_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gfq_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [gfq_pkg::CfgDataW-1:0]  cfg_wdata,
  output gfq_pkg::cfg_t                 cfg
);
  import gfq_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_ENTRY0:  cfg_nxt.entries[0] = cfg_wdata[EntryW-1:0];
        CFG_ENTRY1:  cfg_nxt.entries[1] = cfg_wdata[EntryW-1:0];
        CFG_ENTRY2:  cfg_nxt.entries[2] = cfg_wdata[EntryW-1:0];
        CFG_ENTRY3:  cfg_nxt.entries[3] = cfg_wdata[EntryW-1:0];
        CFG_BYPASS:  cfg_nxt.bypass = cfg_wdata[0];
        CFG_INS_DIM: cfg_nxt.dim = cfg_wdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.entries <= '0;
      cfg_r.bypass <= 1'b0;
      cfg_r.dim <= DimReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/gfq_level_match.sv -----
// Level table lookup: exact status match first, then the wildcard entry.
// Depends on gfq_pkg.
module gfq_level_match (
  input  logic [gfq_pkg::StatusW-1:0] status,
  input  gfq_pkg::cfg_t               cfg,
  output gfq_pkg::match_t             match
);
  import gfq_pkg::*;

  logic                 exact_hit;
  logic                 any_hit;
  logic [EntryIdxW-1:0] exact_idx;
  logic [EntryIdxW-1:0] any_idx;
  logic [EntryIdxW-1:0] sel_idx;

  always_comb begin
    exact_hit = 1'b0;
    any_hit = 1'b0;
    exact_idx = '0;
    any_idx = '0;
    // Walk downward so the lowest matching entry wins.
    for (int k = ScanLevels - 1; k >= 0; k--) begin
      if (entry_en(cfg.entries[k]) &&
          entry_status(cfg.entries[k]) == {1'b0, status}) begin
        exact_hit = 1'b1;
        exact_idx = EntryIdxW'(k);
      end
      if (entry_en(cfg.entries[k]) && entry_status(cfg.entries[k]) == StatusAny) begin
        any_hit = 1'b1;
        any_idx = EntryIdxW'(k);
      end
    end
  end

  always_comb begin
    sel_idx = exact_hit ? exact_idx : any_idx;
    if (exact_hit || any_hit) begin
      match.level = level_t'({1'b0, sel_idx});
    end else begin
      match.level = LevelNone;
    end
    match.dwell_us = entry_dwell_us(cfg.entries[sel_idx]);
  end

endmodule

// ----- sv/gnss_fix_quality_qualifier.sv -----
// GNSS/INS fix quality qualifier top level.
// Each accepted fix report on in_ch yields exactly one result on out_ch.
// The report is first captured in an input register; from there the
// level table lookup, loss timeout and dwell checks run and the result is
// written to the output register while the held level and held time update.
// Throughput: one report per cycle while out_ch.ready stays high; the state
// update loop of held level and held time closes within the compute stage.
// A result waiting on a stalled receiver stays in the output register; the
// input register keeps taking a report as long as the compute stage can move.
// When out_ch.ready stays low both registers fill and in_ch.ready drops.
// Configuration is written through cfg_we/cfg_idx/cfg_wdata; the user must
// do so only while no report is in flight, the block does not enforce it.
// Reset (rst_n low, synchronous) empties both registers, sets the held level
// to none, the held time to zero, and the table to defaults.
// Depends on gfq_pkg, gfq_in_if, gfq_out_if, gfq_cfg_regs, gfq_level_match.
module gnss_fix_quality_qualifier (
  input  logic                          clk,
  input  logic                          rst_n,
  gfq_in_if.sink                        in_ch,
  gfq_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [gfq_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [gfq_pkg::CfgDataW-1:0]  cfg_wdata
);
  import gfq_pkg::*;

  `include "gnss_fix_quality_qualifier_assert.svh"

  cfg_t   cfg;
  match_t match;

  logic                   in_valid_r;
  logic                   in_valid_nxt;
  logic [TimeW-1:0]       frame_time_r;
  logic [TimeW-1:0]       fix_time_r;
  logic [StatusW-1:0]     status_r;
  logic signed [LatW-1:0] lat_r;
  logic signed [LonW-1:0] lon_r;

  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_fix_valid_r;
  logic             out_attr_r;
  level_t           out_level_r;
  logic [DimW-1:0]  out_dim_r;
  logic [PrecW-1:0] out_prec_r;

  level_t           held_level_r;
  level_t           held_level_nxt;
  logic [TimeW-1:0] held_time_r;
  logic [TimeW-1:0] held_time_nxt;

  logic             advance;
  logic             in_accept;
  logic             report_invalid;
  logic             loss_elapsed;
  logic             dwell_elapsed;
  level_t           used;
  logic             res_fix_valid;
  logic             res_attr;
  level_t           res_level;
  logic [DimW-1:0]  res_dim;
  logic [PrecW-1:0] res_prec;

  gfq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gfq_level_match u_match (
    .status (status_r),
    .cfg    (cfg),
    .match  (match)
  );

  assign advance = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_accept = in_ch.valid && in_ch.ready;
  assign in_valid_nxt = in_accept || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ch.ready);

  assign report_invalid = (status_r == '0) &&
                          (lat_r > LatNearLo) && (lat_r < LatNearHi) &&
                          (lon_r > LonNearLo) && (lon_r < LonNearHi);
  assign loss_elapsed = elapsed_at_least(frame_time_r, held_time_r, LossTimeoutUs);
  assign dwell_elapsed = elapsed_at_least(fix_time_r, held_time_r,
                                          TimeW'(match.dwell_us));

  always_comb begin
    held_level_nxt = held_level_r;
    held_time_nxt = held_time_r;
    used = LevelNone;
    res_fix_valid = 1'b0;
    res_attr = 1'b0;
    res_level = LevelNone;
    res_dim = '0;
    res_prec = '0;
    if (report_invalid) begin
      if (held_level_r != LevelNone && loss_elapsed) begin
        held_level_nxt = LevelNone;
      end
    end else if (cfg.bypass) begin
      res_fix_valid = 1'b1;
    end else begin
      if (match.level == held_level_r) begin
        used = match.level;
        held_time_nxt = fix_time_r;
      end else if (match.level < held_level_r || dwell_elapsed) begin
        used = match.level;
        held_level_nxt = match.level;
        held_time_nxt = fix_time_r;
      end else begin
        used = held_level_r;
      end
      if (used != LevelNone) begin
        res_fix_valid = 1'b1;
        res_attr = 1'b1;
        res_level = used;
        res_dim = cfg.dim;
        res_prec = entry_prec(cfg.entries[used[EntryIdxW-1:0]]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      held_level_r <= LevelNone;
      held_time_r <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        held_level_r <= held_level_nxt;
        held_time_r <= held_time_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      frame_time_r <= in_ch.frame_time_us;
      fix_time_r <= in_ch.fix_time_us;
      status_r <= in_ch.fix_status;
      lat_r <= in_ch.latitude_e7;
      lon_r <= in_ch.longitude_e7;
    end
    if (advance) begin
      out_fix_valid_r <= res_fix_valid;
      out_attr_r <= res_attr;
      out_level_r <= res_level;
      out_dim_r <= res_dim;
      out_prec_r <= res_prec;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.fix_valid = out_fix_valid_r;
  assign out_ch.attributes_set = out_attr_r;
  assign out_ch.level = out_level_r;
  assign out_ch.dimension_out = out_dim_r;
  assign out_ch.precision_out = out_prec_r;

  `GFQ_ASSERT_NEXT(a_state_holds_when_idle, !advance,
                   $stable(held_level_r) && $stable(held_time_r))
  `GFQ_ASSERT_NEXT(a_bypass_keeps_state, advance && cfg.bypass && !report_invalid,
                   $stable(held_level_r) && $stable(held_time_r))
  `GFQ_ASSERT_NEXT(a_invalid_keeps_time, advance && report_invalid, $stable(held_time_r))
  `GFQ_ASSERT_SAME(a_attr_has_level, out_valid_r && out_attr_r,
                   out_fix_valid_r && out_level_r != LevelNone)
  `GFQ_ASSERT_SAME(a_unused_is_blank, out_valid_r && !out_fix_valid_r,
                   out_level_r == LevelNone && out_prec_r == '0 && out_dim_r == '0)

endmodule
